@@ design/grid_max_path_traceback_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the grid max-path traceback block
// ---------------------------------------------------------------------------
`ifndef GRID_MAX_PATH_TRACEBACK_MACROS_SVH
`define GRID_MAX_PATH_TRACEBACK_MACROS_SVH

// Same-cycle implication.
`define GMP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define GMP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/gmp_pkg.sv @@
// ---------------------------------------------------------------------------
// gmp_pkg
// Shared types, constants and the saturating score add.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package gmp_pkg;

   localparam int MAX_ROWS_DEF    = 64;
   localparam int MAX_COLUMNS_DEF = 32;
   localparam int VALUE_BITS_DEF  = 32;

   localparam int SCORE_W  = 48;
   localparam int CELL_W   = 32;
   localparam int ROWCFG_W = 7;
   localparam int COLCFG_W = 6;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMN_COUNT = 2'd1;

   localparam logic [1:0] PRED_UP    = 2'd0;
   localparam logic [1:0] PRED_LEVEL = 2'd1;
   localparam logic [1:0] PRED_DOWN  = 2'd2;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SWEEP,
      ST_TB_ISSUE,
      ST_TB_WAIT,
      ST_OUT_SCORE,
      ST_OUT_PATH
   } state_type;

   localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
   localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

   function automatic logic signed [SCORE_W-1:0] sat_add(
      input logic signed [SCORE_W-1:0] a,
      input logic signed [SCORE_W-1:0] b);
      logic signed [SCORE_W:0] s;
      logic signed [SCORE_W-1:0] r;
      s = {a[SCORE_W-1], a} + {b[SCORE_W-1], b};
      if (s[SCORE_W] != s[SCORE_W-1]) begin
         r = s[SCORE_W] ? SCORE_MIN : SCORE_MAX;
      end else begin
         r = s[SCORE_W-1:0];
      end
      return r;
   endfunction

endpackage

@@ design/gmp_ram.sv @@
// ---------------------------------------------------------------------------
// gmp_ram
// Simple dual-port RAM: one write, one read, registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gmp_ram #(
   parameter int DATA_W = 32,
   parameter int ADDR_W = 11
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

@@ design/grid_max_path_traceback.sv @@
// ---------------------------------------------------------------------------
// grid_max_path_traceback
// Left-to-right max-sum grid path with three-neighbor moves and traceback.
// ---------------------------------------------------------------------------
// Usage:
//  - Set row_count (index 0) and column_count (index 1) over the csr_ port
//    while the block is idle. A write to either count register restarts grid loading.
//  - Cells transfer one per cycle, row-major, on start/req_cell_value while
//    busy is low. Loading sustains one cell per clock.
//  - After the final cell, busy rises. The sweep works column by column (n rows
//    each) through the single read port of the score RAM, whose read data is
//    registered; traceback walks the columns back through the predecessor
//    RAM; then 1 + m results go out on consecutive cycles.
//  - Results: rsp_strobe marks each transfer for one cycle; the score result
//    comes first, then path steps from the first column, last_step on the
//    final one. The receiver cannot stall; there is no back pressure.
//  - Reset (synchronous) sets row_count and column_count to 1, clears the load
//    position and returns to loading. Memories are not cleared: every entry
//    whose read data is used is written in a run before it is read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_max_path_traceback import gmp_pkg::*; #(
   parameter int MAX_ROWS    = MAX_ROWS_DEF,
   parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
   parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   // cell input channel
   input  logic                       start,
   output logic                       busy,
   input  logic signed [CELL_W-1:0]   req_cell_value,
   // register write channel
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [ROWCFG_W-1:0]        csr_wdata,
   // result channel
   output logic                       rsp_strobe,
   output logic                       rsp_is_score,
   output logic signed [SCORE_W-1:0]  rsp_best_score,
   output logic [ROWCFG_W-1:0]        rsp_path_row,
   output logic [COLCFG_W-1:0]        rsp_path_column,
   output logic                       rsp_last_step
);

   `include "grid_max_path_traceback_macros.svh"

   localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int RN_W  = $clog2(MAX_ROWS + 1);
   localparam int CN_W  = $clog2(MAX_COLUMNS + 1);
   localparam int T_W   = $clog2(MAX_ROWS + 2);
   localparam int GRID_AW = ROW_W + COL_W;

   // ---------------- registers ----------------
   state_type state_ff, state_in;

   logic [ROWCFG_W-1:0] row_cfg_ff, row_cfg_in;
   logic [COLCFG_W-1:0] col_cfg_ff, col_cfg_in;

   logic [ROW_W-1:0] ld_row_ff, ld_row_in;
   logic [COL_W-1:0] ld_col_ff, ld_col_in;

   logic [T_W-1:0]   t_ff, t_in;        // sweep sequencer count within a column
   logic [COL_W-1:0] col_ff, col_in;    // sweep / traceback column

   // sliding window over the previous column: rows r-1 and r
   logic signed [SCORE_W-1:0] win_a_ff, win_a_in;
   logic signed [SCORE_W-1:0] win_b_ff, win_b_in;

   logic signed [SCORE_W-1:0] best_ff, best_in;
   logic [ROW_W-1:0]          best_row_ff, best_row_in;
   logic [ROW_W-1:0]          tb_row_ff, tb_row_in;

   logic [ROW_W-1:0] path_ff [MAX_COLUMNS];
   logic             path_we;

   logic [COL_W-1:0] out_col_ff, out_col_in;

   logic                      rsp_strobe_ff, rsp_strobe_in;
   logic                      rsp_is_score_ff, rsp_is_score_in;
   logic signed [SCORE_W-1:0] rsp_best_ff, rsp_best_in;
   logic [ROWCFG_W-1:0]       rsp_row_ff, rsp_row_in;
   logic [COLCFG_W-1:0]       rsp_col_ff, rsp_col_in;
   logic                      rsp_last_ff, rsp_last_in;

   // ---------------- effective sizes ----------------
   logic [RN_W-1:0] rows_n;
   logic [CN_W-1:0] cols_m;

   always_comb begin
      priority if (row_cfg_ff == '0) begin
         rows_n = RN_W'(1);
      end else if (int'(row_cfg_ff) > MAX_ROWS) begin
         rows_n = RN_W'(MAX_ROWS);
      end else begin
         rows_n = RN_W'(row_cfg_ff);
      end
      priority if (col_cfg_ff == '0) begin
         cols_m = CN_W'(1);
      end else if (int'(col_cfg_ff) > MAX_COLUMNS) begin
         cols_m = CN_W'(MAX_COLUMNS);
      end else begin
         cols_m = CN_W'(col_cfg_ff);
      end
   end

   logic [ROW_W-1:0] last_row;
   logic [COL_W-1:0] last_col;
   assign last_row = ROW_W'(rows_n - RN_W'(1));
   assign last_col = COL_W'(cols_m - CN_W'(1));

   // ---------------- memories ----------------
   logic                     cell_we;
   logic [GRID_AW-1:0]       cell_waddr, cell_raddr;
   logic [VALUE_BITS-1:0]    cell_rdata;

   logic                     sc_we;
   logic [ROW_W:0]           sc_waddr, sc_raddr;
   logic [SCORE_W-1:0]       sc_wdata, sc_rdata;

   logic                     pred_we;
   logic [GRID_AW-1:0]       pred_waddr, pred_raddr;
   logic [1:0]               pred_wdata, pred_rdata;

   gmp_ram #(.DATA_W(VALUE_BITS), .ADDR_W(GRID_AW)) u_cell_ram (
      .clock   (clock),
      .wr_en   (cell_we),
      .wr_addr (cell_waddr),
      .wr_data (req_cell_value[VALUE_BITS-1:0]),
      .rd_addr (cell_raddr),
      .rd_data (cell_rdata)
   );

   // two banks of 2**ROW_W scores (at least MAX_ROWS): previous and current column, by parity
   gmp_ram #(.DATA_W(SCORE_W), .ADDR_W(ROW_W + 1)) u_score_ram (
      .clock   (clock),
      .wr_en   (sc_we),
      .wr_addr (sc_waddr),
      .wr_data (sc_wdata),
      .rd_addr (sc_raddr),
      .rd_data (sc_rdata)
   );

   gmp_ram #(.DATA_W(2), .ADDR_W(GRID_AW)) u_pred_ram (
      .clock   (clock),
      .wr_en   (pred_we),
      .wr_addr (pred_waddr),
      .wr_data (pred_wdata),
      .rd_addr (pred_raddr),
      .rd_data (pred_rdata)
   );

   // ---------------- handshakes ----------------
   logic item_acc, csr_acc, ld_last;

   assign busy      = (state_ff != ST_LOAD);
   assign csr_ready = !busy;
   assign item_acc  = start && !busy;
   assign csr_acc   = csr_valid && csr_ready;
   assign ld_last   = (ld_row_ff == last_row) && (ld_col_ff == last_col);

   assign cell_we    = item_acc;
   assign cell_waddr = {ld_row_ff, ld_col_ff};

   // ---------------- sweep datapath ----------------
   // Count t: read prev row t and cell row t-1; read data is registered, so
   // row t-2 is finished at count t with prev rows t-3, t-2 in the window
   // and prev row t-1 on the RAM output.
   logic [ROW_W-1:0]          sw_row;
   logic                      sw_work, sw_has_up, sw_has_down, sw_last_col;
   logic signed [SCORE_W-1:0] prev_down, cell_ext, mx, new_score;
   logic [1:0]                code;

   assign sw_row      = ROW_W'(t_ff - T_W'(2));
   assign sw_work     = (state_ff == ST_SWEEP) && (t_ff >= T_W'(2));
   assign sw_has_up   = (sw_row != '0);
   assign sw_has_down = (sw_row < last_row);
   assign sw_last_col = (col_ff == last_col);
   assign prev_down   = sc_rdata;
   assign cell_ext    = SCORE_W'(signed'(cell_rdata));

   always_comb begin
      mx   = win_b_ff;
      code = PRED_LEVEL;
      if (sw_has_up && (win_a_ff >= mx)) begin
         mx   = win_a_ff;
         code = PRED_UP;
      end
      if (sw_has_down && (prev_down > mx)) begin
         mx   = prev_down;
         code = PRED_DOWN;
      end
      new_score = (col_ff == '0) ? cell_ext : sat_add(mx, cell_ext);
   end

   assign cell_raddr = {ROW_W'(t_ff - T_W'(1)), col_ff};
   assign sc_raddr   = {~col_ff[0], ROW_W'(t_ff)};
   assign sc_we      = sw_work;
   assign sc_waddr   = {col_ff[0], sw_row};
   assign sc_wdata   = new_score;
   assign pred_we    = sw_work && (col_ff != '0);
   assign pred_waddr = {sw_row, col_ff};
   assign pred_wdata = code;
   assign pred_raddr = {tb_row_ff, col_ff};

   // ---------------- control ----------------
   always_comb begin
      state_in   = state_ff;
      row_cfg_in = row_cfg_ff;
      col_cfg_in = col_cfg_ff;
      ld_row_in  = ld_row_ff;
      ld_col_in  = ld_col_ff;
      t_in       = t_ff;
      col_in     = col_ff;
      win_a_in   = win_a_ff;
      win_b_in   = win_b_ff;
      best_in    = best_ff;
      best_row_in = best_row_ff;
      tb_row_in  = tb_row_ff;
      out_col_in = out_col_ff;
      path_we    = 1'b0;

      rsp_strobe_in   = 1'b0;
      rsp_is_score_in = 1'b0;
      rsp_best_in     = '0;
      rsp_row_in      = '0;
      rsp_col_in      = '0;
      rsp_last_in     = 1'b0;

      unique case (state_ff)
         ST_LOAD: begin
            if (item_acc) begin
               if (ld_last) begin
                  ld_row_in = '0;
                  ld_col_in = '0;
                  t_in      = '0;
                  col_in    = '0;
                  state_in  = ST_SWEEP;
               end else if (ld_col_ff == last_col) begin
                  ld_col_in = '0;
                  ld_row_in = ld_row_ff + ROW_W'(1);
               end else begin
                  ld_col_in = ld_col_ff + COL_W'(1);
               end
            end
            // a write to the row or column count restarts loading
            if (csr_acc) begin
               if (csr_index == CSR_ROW_COUNT) begin
                  row_cfg_in = csr_wdata;
                  ld_row_in  = '0;
                  ld_col_in  = '0;
               end else if (csr_index == CSR_COLUMN_COUNT) begin
                  col_cfg_in = csr_wdata[COLCFG_W-1:0];
                  ld_row_in  = '0;
                  ld_col_in  = '0;
               end
            end
         end

         ST_SWEEP: begin
            if (t_ff >= T_W'(1)) begin
               win_a_in = win_b_ff;
               win_b_in = prev_down;
            end
            if (sw_work && sw_last_col &&
                ((sw_row == '0) || (new_score > best_ff))) begin
               best_in     = new_score;
               best_row_in = sw_row;
            end
            if (t_ff == (T_W'(rows_n) + T_W'(1))) begin
               t_in = '0;
               if (sw_last_col) begin
                  tb_row_in = best_row_in;
                  state_in  = ST_TB_ISSUE;
               end else begin
                  col_in = col_ff + COL_W'(1);
               end
            end else begin
               t_in = t_ff + T_W'(1);
            end
         end

         ST_TB_ISSUE: begin
            path_we = 1'b1;
            if (col_ff == '0) begin
               state_in = ST_OUT_SCORE;
            end else begin
               state_in = ST_TB_WAIT;
            end
         end

         ST_TB_WAIT: begin
            if ((pred_rdata == PRED_UP) && (tb_row_ff != '0)) begin
               tb_row_in = tb_row_ff - ROW_W'(1);
            end else if ((pred_rdata == PRED_DOWN) && (tb_row_ff < last_row)) begin
               tb_row_in = tb_row_ff + ROW_W'(1);
            end
            col_in   = col_ff - COL_W'(1);
            state_in = ST_TB_ISSUE;
         end

         ST_OUT_SCORE: begin
            rsp_strobe_in   = 1'b1;
            rsp_is_score_in = 1'b1;
            rsp_best_in     = best_ff;
            out_col_in      = '0;
            state_in        = ST_OUT_PATH;
         end

         ST_OUT_PATH: begin
            rsp_strobe_in = 1'b1;
            rsp_row_in    = ROWCFG_W'(path_ff[out_col_ff]) + ROWCFG_W'(1);
            rsp_col_in    = COLCFG_W'(out_col_ff) + COLCFG_W'(1);
            rsp_last_in   = (out_col_ff == last_col);
            out_col_in    = out_col_ff + COL_W'(1);
            if (out_col_ff == last_col) begin
               state_in = ST_LOAD;
            end
         end

         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         row_cfg_ff    <= ROWCFG_W'(1);
         col_cfg_ff    <= COLCFG_W'(1);
         ld_row_ff     <= '0;
         ld_col_ff     <= '0;
         t_ff          <= '0;
         col_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_cfg_ff    <= row_cfg_in;
         col_cfg_ff    <= col_cfg_in;
         ld_row_ff     <= ld_row_in;
         ld_col_ff     <= ld_col_in;
         t_ff          <= t_in;
         col_ff        <= col_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      win_a_ff        <= win_a_in;
      win_b_ff        <= win_b_in;
      best_ff         <= best_in;
      best_row_ff     <= best_row_in;
      tb_row_ff       <= tb_row_in;
      out_col_ff      <= out_col_in;
      rsp_is_score_ff <= rsp_is_score_in;
      rsp_best_ff     <= rsp_best_in;
      rsp_row_ff      <= rsp_row_in;
      rsp_col_ff      <= rsp_col_in;
      rsp_last_ff     <= rsp_last_in;
      if (path_we) begin
         path_ff[col_ff] <= tb_row_ff;
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_is_score    = rsp_is_score_ff;
   assign rsp_best_score  = rsp_best_ff;
   assign rsp_path_row    = rsp_row_ff;
   assign rsp_path_column = rsp_col_ff;
   assign rsp_last_step   = rsp_last_ff;

   // ---------------- assertions ----------------
   `GMP_ASSERT_NEXT(a_score_first, clock, reset, state_ff == ST_OUT_SCORE, rsp_strobe && rsp_is_score, "score result must follow traceback")
   `GMP_ASSERT_NOW(a_sweep_row, clock, reset, sc_we, RN_W'(sw_row) < rows_n, "sweep wrote a row beyond row count")
   `GMP_ASSERT_NOW(a_last_col, clock, reset, rsp_strobe && rsp_last_step, !rsp_is_score && (rsp_path_column == COLCFG_W'(cols_m)), "last step not on last column")

endmodule
